>>> design/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared constants and types for the Otsu threshold block.
// ----------------------------------------------------------------------------
package otsu_pkg;

  // Default image size limit (log2 of pixel count) and histogram depth
  localparam int MAX_PIXELS_LOG2_DEF = 20;
  localparam int GRAY_LEVELS_DEF     = 256;

  // Width of the pixel port
  localparam int PIXEL_W = 8;

  // Depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // One queued pixel request: clamped level and end-of-image mark
  typedef struct packed {
    logic [PIXEL_W-1:0] level;
    logic               last;
  } item_t;

endpackage

>>> design/otsu_serial_mul.sv
// ----------------------------------------------------------------------------
// otsu_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module otsu_serial_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW+BW-1:0] prod
);

  localparam int PW   = AW + BW;
  localparam int CNTW = $clog2(BW + 1);

  logic [PW-1:0]   acc;
  logic [PW-1:0]   mcand;
  logic [BW-1:0]   mplier;
  logic [CNTW-1:0] cnt;
  logic            busy;

  // Control: run for BW steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(BW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: add shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PW'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign done = ~busy;
  assign prod = acc;

endmodule

>>> design/otsu_front.sv
// ----------------------------------------------------------------------------
// otsu_front
// Accepts pixel requests, clamps the level and queues them for the back end.
// ----------------------------------------------------------------------------
module otsu_front #(
  parameter int GRAY_LEVELS = otsu_pkg::GRAY_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [otsu_pkg::PIXEL_W-1:0] pixel,
  input  logic                         last_pixel,
  output logic                         q_valid,
  input  logic                         q_ready,
  output otsu_pkg::item_t              q_item
);

  localparam int DEPTH = otsu_pkg::QUEUE_DEPTH;
  localparam int PTRW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int CMPW  = otsu_pkg::PIXEL_W + 1;

  otsu_pkg::item_t entries [DEPTH];
  otsu_pkg::item_t item_in;
  logic [PTRW-1:0] wptr;
  logic [PTRW-1:0] rptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  // Clamp levels beyond the histogram to the top bin
  always_comb begin
    item_in.last = last_pixel;
    if (CMPW'(pixel) >= CMPW'(GRAY_LEVELS)) begin
      item_in.level = otsu_pkg::PIXEL_W'(GRAY_LEVELS - 1);
    end else begin
      item_in.level = pixel;
    end
  end

  assign in_ready = (count != CNTW'(DEPTH));
  assign push     = in_valid & in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid & q_ready;
  assign q_item   = entries[rptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + PTRW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

>>> design/otsu_back.sv
// ----------------------------------------------------------------------------
// otsu_back
// Histogram update pipeline and per-level threshold search sequencer.
// ----------------------------------------------------------------------------
module otsu_back #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int GRAY_LEVELS     = otsu_pkg::GRAY_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  otsu_pkg::item_t              q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [otsu_pkg::PIXEL_W-1:0] threshold_level,
  output logic                         split_found
);

  localparam int CW   = MAX_PIXELS_LOG2 + 1;
  localparam int LW   = $clog2(GRAY_LEVELS);
  localparam int SW   = CW + LW;
  localparam int PW   = SW + CW;
  localparam int CCW  = 2 * CW;
  localparam int D2W  = 2 * PW;
  localparam int XW   = D2W + CCW;

  typedef enum logic [8:0] {
    S_HIST  = 9'b000000001,
    S_DRAIN = 9'b000000010,
    S_RD    = 9'b000000100,
    S_ACC   = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_M1    = 9'b000100000,
    S_M2    = 9'b001000000,
    S_M3    = 9'b010000000,
    S_NEXT  = 9'b100000000
  } state_t;

  state_t state;

  // Histogram storage
  logic [CW-1:0]          mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] bin_valid;
  logic [CW-1:0]          rd_data;
  logic                   rd_vld;
  logic [CW-1:0]          rd_val;
  logic                   rd_en;
  logic [LW-1:0]          rd_addr;

  // Update pipeline
  logic          pop;
  logic          s1_act;
  logic [LW-1:0] s1_lvl;
  logic          byp_en;
  logic [LW-1:0] byp_lvl;
  logic [CW-1:0] byp_val;
  logic [CW-1:0] wr_data;

  // Totals and search state
  logic [CW-1:0]  n;
  logic [SW-1:0]  st;
  logic [CW-1:0]  c0;
  logic [SW-1:0]  s0;
  logic [CW-1:0]  c1;
  logic [LW-1:0]  t;
  logic           found;
  logic [LW-1:0]  best_t;
  logic [D2W-1:0] best_d2;
  logic [CCW-1:0] best_cc;
  logic [CCW-1:0] cc;
  logic [PW-1:0]  dabs;

  // Multiplier units
  logic           start1;
  logic           start2;
  logic           start3;
  logic           p_done;
  logic           q_done;
  logic           cc_done;
  logic           sq_done;
  logic           lhs_done;
  logic           rhs_done;
  logic [PW-1:0]  p_prod;
  logic [PW-1:0]  q_prod;
  logic [CCW-1:0] cc_prod;
  logic [D2W-1:0] d2;
  logic [XW-1:0]  lhs;
  logic [XW-1:0]  rhs;
  logic           commit;

  assign q_ready = (state == S_HIST);
  assign pop     = q_valid & q_ready;
  assign rd_en   = pop | (state == S_RD);
  assign rd_addr = (state == S_HIST) ? q_item.level[LW-1:0] : t;
  assign rd_val  = rd_vld ? rd_data : '0;
  assign c1      = n - c0;
  assign dabs    = (p_prod >= q_prod) ? p_prod - q_prod : q_prod - p_prod;
  assign commit  = (state == S_NEXT) && (t == LW'(GRAY_LEVELS - 1)) &&
                   (!out_valid || out_ready);

  // Read bin count, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= bin_valid[rd_addr];
    end
  end

  // Increment with forwarding from the previous write
  assign wr_data = ((byp_en && byp_lvl == s1_lvl) ? byp_val : rd_val) + CW'(1);

  always_ff @(posedge clk) begin
    if (s1_act) begin
      mem[s1_lvl] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    byp_lvl <= s1_lvl;
    byp_val <= wr_data;
  end

  // Bin valid bits, cleared at reset and after each image
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      s1_act    <= 1'b0;
      byp_en    <= 1'b0;
    end else begin
      byp_en <= s1_act;
      s1_act <= pop && !n[CW-1];
      if (commit) begin
        bin_valid <= '0;
      end else if (s1_act) begin
        bin_valid[s1_lvl] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_lvl <= q_item.level[LW-1:0];
    end
  end

  // Multipliers: p = S0*N, q = ST*C0, cc = C0*C1
  otsu_serial_mul #(.AW(SW), .BW(CW)) u_mul_p (
    .clk(clk), .rst(rst), .start(start1), .a(s0), .b(n),
    .done(p_done), .prod(p_prod)
  );
  otsu_serial_mul #(.AW(SW), .BW(CW)) u_mul_q (
    .clk(clk), .rst(rst), .start(start1), .a(st), .b(c0),
    .done(q_done), .prod(q_prod)
  );
  otsu_serial_mul #(.AW(CW), .BW(CW)) u_mul_cc (
    .clk(clk), .rst(rst), .start(start1), .a(c0), .b(c1),
    .done(cc_done), .prod(cc_prod)
  );
  // Square of the class difference
  otsu_serial_mul #(.AW(PW), .BW(PW)) u_mul_sq (
    .clk(clk), .rst(rst), .start(start2), .a(dabs), .b(dabs),
    .done(sq_done), .prod(d2)
  );
  // Cross products for the score compare
  otsu_serial_mul #(.AW(D2W), .BW(CCW)) u_mul_lhs (
    .clk(clk), .rst(rst), .start(start3), .a(d2), .b(best_cc),
    .done(lhs_done), .prod(lhs)
  );
  otsu_serial_mul #(.AW(D2W), .BW(CCW)) u_mul_rhs (
    .clk(clk), .rst(rst), .start(start3), .a(best_d2), .b(cc),
    .done(rhs_done), .prod(rhs)
  );

  assign start1 = (state == S_CHK) && (c0 != '0) && (c1 != '0);
  assign start2 = (state == S_M1) && p_done;
  assign start3 = (state == S_M2) && sq_done && found;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HIST;
      n         <= '0;
      st        <= '0;
      c0        <= '0;
      s0        <= '0;
      t         <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_HIST: begin
          if (pop) begin
            if (!n[CW-1]) begin
              n  <= n + CW'(1);
              st <= st + SW'(q_item.level[LW-1:0]);
            end
            if (q_item.last) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          state <= S_RD;
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          c0    <= c0 + rd_val;
          s0    <= s0 + SW'(rd_val) * SW'(t);
          state <= S_CHK;
        end
        S_CHK: begin
          state <= start1 ? S_M1 : S_NEXT;
        end
        S_M1: begin
          if (p_done) begin
            state <= S_M2;
          end
        end
        S_M2: begin
          if (sq_done) begin
            state <= found ? S_M3 : S_NEXT;
          end
        end
        S_M3: begin
          if (lhs_done) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (t != LW'(GRAY_LEVELS - 1)) begin
            t     <= t + LW'(1);
            state <= S_RD;
          end else if (commit) begin
            out_valid <= 1'b1;
            n         <= '0;
            st        <= '0;
            c0        <= '0;
            s0        <= '0;
            t         <= '0;
            found     <= 1'b0;
            state     <= S_HIST;
          end
        end
        default: begin
          state <= S_HIST;
        end
      endcase
      if ((state == S_M2) && sq_done && !found) begin
        found <= 1'b1;
      end
    end
  end

  // Best-score tracking
  always_ff @(posedge clk) begin
    if (start2) begin
      cc <= cc_prod;
    end
    if ((state == S_M2) && sq_done && !found) begin
      best_d2 <= d2;
      best_cc <= cc;
      best_t  <= t;
    end else if ((state == S_M3) && lhs_done && (lhs > rhs)) begin
      best_d2 <= d2;
      best_cc <= cc;
      best_t  <= t;
    end
    if (commit) begin
      threshold_level <= found ? otsu_pkg::PIXEL_W'(best_t) : '0;
      split_found     <= found;
    end
  end

`ifndef SYNTHESIS
  // No pixel request leaves the queue outside the histogram phase
  a_pop_hist: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_HIST))
    else $error("pixel taken during threshold search");

  // First-stage products finish together
  a_mul_sync: assert property (@(posedge clk) disable iff (rst)
    (p_done == q_done) && (p_done == cc_done))
    else $error("first-stage multipliers out of step");

  // Cross products finish together
  a_cross_sync: assert property (@(posedge clk) disable iff (rst)
    lhs_done == rhs_done)
    else $error("cross-product multipliers out of step");

  // Pixel count never passes the cap
  a_cap: assert property (@(posedge clk) disable iff (rst)
    n[CW-1] |-> (n[CW-2:0] == '0))
    else $error("pixel count beyond cap");

  // A committed result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(threshold_level))
    else $error("pending result overwritten");
`endif

endmodule

>>> design/otsu_threshold.sv
// ----------------------------------------------------------------------------
// otsu_threshold
// Otsu gray-level threshold over one streamed image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, pixel, last_pixel) takes one pixel per
//   cycle while the histogram phase runs; requests go through a 4-entry
//   queue, so the input keeps flowing until the queue fills while the back end
//   is busy. The pixel marked last closes the image and starts the search.
//   Output channel (out_valid/out_ready, threshold_level, split_found)
//   carries one result per image from an output register.
//   After the last pixel the back end passes a drain state and then scans
//   the levels: each level reads its bin, adds it to the class totals and
//   checks the split. A level whose split leaves both classes non-empty then
//   runs the first-stage products, the square of the class difference and,
//   after the first such level, the cross products. The shift-add multipliers
//   work one bit per cycle. New pixels are not taken from the queue during
//   the search. Reset (synchronous) clears the histogram valid bits and
//   totals. If the receiver stalls, a result waits in the output register;
//   the next image may be counted meanwhile, but its search holds before
//   commit until the old result is taken.
// ----------------------------------------------------------------------------
module otsu_threshold #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int GRAY_LEVELS     = otsu_pkg::GRAY_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [otsu_pkg::PIXEL_W-1:0] pixel,
  input  logic                         last_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [otsu_pkg::PIXEL_W-1:0] threshold_level,
  output logic                         split_found
);

  logic            q_valid;
  logic            q_ready;
  otsu_pkg::item_t q_item;

  // Accept and queue pixel requests
  otsu_front #(.GRAY_LEVELS(GRAY_LEVELS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel(pixel), .last_pixel(last_pixel),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  // Count and search
  otsu_back #(
    .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2),
    .GRAY_LEVELS(GRAY_LEVELS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .threshold_level(threshold_level), .split_found(split_found)
  );

endmodule
